FILE: src/qbvs_pkg.sv
// ----------------------------------------------------------------------------
// qbvs_pkg
// Shared types, constants and tables of the quad batch vertex setup block.
// ----------------------------------------------------------------------------
package qbvs_pkg;

  localparam int SLOT_COUNT   = 16;
  localparam int TEX_ID_BITS  = 16;
  localparam int CORDIC_STEPS = 16;

  localparam int SLOT_W  = $clog2(SLOT_COUNT);
  localparam int NSLOT_W = $clog2(SLOT_COUNT + 1);
  localparam int NSTEP   = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
  localparam int STEP_W  = $clog2(NSTEP + 1);

  localparam logic signed [35:0] HALF_PI = 36'sd1686629713;
  localparam logic signed [35:0] PI_Q30  = 36'sd3373259426;
  localparam logic signed [35:0] GAIN    = 36'sd652032874;

  localparam logic [1:0] KIND_VERTEX = 2'd0;
  localparam logic [1:0] KIND_BIND   = 2'd1;
  localparam logic [1:0] KIND_DRAW   = 2'd2;

  localparam logic [0:0] REG_QUAD_LIMIT = 1'b0;
  localparam logic [0:0] REG_WHITE_TEX  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SEARCH, ST_FBIND, ST_FDRAW, ST_ALLOC, ST_CORDIC,
    ST_MUL0, ST_MUL1, ST_MUL2, ST_MUL3, ST_ADD, ST_VOUT
  } state_e;

  typedef struct packed {
    logic        start;
    logic        busy;
  } cordic_ctl_t;

  function automatic logic signed [35:0] atan_q30(input logic [4:0] i);
    case (i)
      5'd0:  atan_q30 = 36'sd843314857;
      5'd1:  atan_q30 = 36'sd497837829;
      5'd2:  atan_q30 = 36'sd263043837;
      5'd3:  atan_q30 = 36'sd133525159;
      5'd4:  atan_q30 = 36'sd67021687;
      5'd5:  atan_q30 = 36'sd33543516;
      5'd6:  atan_q30 = 36'sd16775851;
      5'd7:  atan_q30 = 36'sd8388437;
      5'd8:  atan_q30 = 36'sd4194283;
      5'd9:  atan_q30 = 36'sd2097149;
      default: atan_q30 = 36'sd1048576 >>> (i - 5'd10);
    endcase
  endfunction

endpackage

FILE: src/qbvs_ram.sv
// ----------------------------------------------------------------------------
// qbvs_ram
// Generic single-port-write, registered-read RAM.
// ----------------------------------------------------------------------------
module qbvs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

FILE: src/qbvs_cordic.sv
// ----------------------------------------------------------------------------
// qbvs_cordic
// Iterative rotation-mode CORDIC, one micro-rotation per cycle, Q.30.
// ----------------------------------------------------------------------------
module qbvs_cordic (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  qbvs_pkg::cordic_ctl_t     ctl_i,
  input  logic signed [14:0]        angle_i,
  output logic                      done_o,
  output logic signed [35:0]        cos_o,
  output logic signed [35:0]        sin_o
);
  import qbvs_pkg::*;

  logic signed [35:0] x_q, x_d, y_q, y_d, a_q, a_d;
  logic               neg_q, neg_d;
  logic [STEP_W-1:0]  i_q, i_d;
  logic               run_q, run_d;
  logic signed [35:0] a0, dx, dy;

  always_comb begin
    a0 = 36'(angle_i) <<< 18;
    dx = y_q >>> i_q;
    dy = x_q >>> i_q;
    x_d = x_q; y_d = y_q; a_d = a_q; neg_d = neg_q; i_d = i_q; run_d = run_q;
    if (ctl_i.start) begin
      x_d = GAIN; y_d = '0; i_d = '0; run_d = 1'b1; neg_d = 1'b0; a_d = a0;
      if (a0 > HALF_PI) begin
        a_d = a0 - PI_Q30; neg_d = 1'b1;
      end else if (a0 < -HALF_PI) begin
        a_d = a0 + PI_Q30; neg_d = 1'b1;
      end
    end else if (run_q) begin
      if (a_q >= 0) begin
        x_d = x_q - dx; y_d = y_q + dy; a_d = a_q - atan_q30(5'(i_q));
      end else begin
        x_d = x_q + dx; y_d = y_q - dy; a_d = a_q + atan_q30(5'(i_q));
      end
      i_d = i_q + 1'b1;
      if (i_q == STEP_W'(NSTEP - 1)) run_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      i_q   <= '0;
    end else begin
      run_q <= run_d;
      i_q   <= i_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; y_q <= y_d; a_q <= a_d; neg_q <= neg_d;
  end

  assign done_o = ctl_i.busy && !run_q && !ctl_i.start;
  assign cos_o  = neg_q ? -x_q : x_q;
  assign sin_o  = neg_q ? -y_q : y_q;
endmodule

FILE: src/quad_batch_vertex_setup.sv
// ----------------------------------------------------------------------------
// quad_batch_vertex_setup
// Quad batcher: slot lookup, flush sequencing and vertex transform.
// Slot search: the white texture matches at once, else each used table entry
// is read and compared, and a miss allocates the next slot; then a CORDIC and,
// per vertex, states MUL0-MUL3, ADD and VOUT on one shared 36x33 multiplier.
// A new transaction is taken only in IDLE with no output pending. Flush: a bind
// per used slot (slot 1 white, others read), then the draw; output stalls wait.
// Reset is asynchronous: slot 1 white, next slot 2, count 0.
// ----------------------------------------------------------------------------
module quad_batch_vertex_setup (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               mode_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic signed [31:0] size_x_i,
  input  logic signed [31:0] size_y_i,
  input  logic signed [14:0] angle_i,
  input  logic [31:0]        color_rgba_i,
  input  logic [15:0]        texture_id_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         kind_o,
  output logic signed [31:0] vertex_x_o,
  output logic signed [31:0] vertex_y_o,
  output logic signed [31:0] vertex_z_o,
  output logic [31:0]        vertex_color_o,
  output logic               tex_u_o,
  output logic               tex_v_o,
  output logic [3:0]         slot_o,
  output logic [15:0]        bound_texture_o,
  output logic [16:0]        index_count_o,
  output logic               last_o
);
  import qbvs_pkg::*;

  state_e state_q, state_d;
  logic [13:0] limit_q;
  logic [TEX_ID_BITS-1:0] white_q;
  logic [NSLOT_W-1:0] next_q, next_d;
  logic [13:0] count_q, count_d;
  logic flush_ret_q, flush_ret_d;
  logic signed [31:0] px_q, py_q, pz_q, sx_q, sy_q;
  logic signed [14:0] ang_q;
  logic [31:0] col_q;
  logic [TEX_ID_BITS-1:0] tex_q;
  logic [NSLOT_W-1:0] idx_q, idx_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic rd_pend_q, rd_pend_d;
  logic [1:0] corner_q, corner_d;
  logic signed [68:0] acc_q, acc_d;
  logic signed [68:0] prod_q;
  logic signed [35:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [31:0] vx_q, vx_d;
  logic ov_q, ov_d;
  logic [1:0] okind_q, okind_d;
  logic signed [31:0] ox_q, ox_d, oy_q, oy_d;
  logic ou_q, ou_d, ovv_q, ovv_d, olast_q, olast_d;
  logic [3:0] oslot_q, oslot_d;
  logic [15:0] otex_q, otex_d;
  logic [16:0] ocnt_q, ocnt_d;
  logic ram_we;
  logic [SLOT_W-1:0] ram_wa, ram_ra;
  logic [TEX_ID_BITS-1:0] ram_rd;
  cordic_ctl_t cctl;
  logic cdone;
  logic signed [35:0] cosv, sinv;
  logic signed [32:0] hx, hy;
  logic signed [68:0] rnd;
  logic signed [31:0] vbase;
  logic signed [37:0] vsum;
  logic signed [31:0] vsat;
  logic out_free, accept;

  qbvs_ram #(.WIDTH(TEX_ID_BITS), .DEPTH(SLOT_COUNT)) u_slots (
    .clk_i, .we_i(ram_we), .waddr_i(ram_wa), .wdata_i(tex_q),
    .raddr_i(ram_ra), .rdata_o(ram_rd)
  );

  qbvs_cordic u_cordic (
    .clk_i, .rst_ni, .ctl_i(cctl), .angle_i(ang_q), .done_o(cdone),
    .cos_o(cosv), .sin_o(sinv)
  );

  assign out_free   = !ov_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && !ov_q;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    hx = (corner_q == 2'd0 || corner_q == 2'd3) ? -33'(sx_q) : 33'(sx_q);
    hy = (corner_q[1]) ? -33'(sy_q) : 33'(sy_q);
    rnd   = acc_q + (69'sd1 <<< 30);
    vbase = (state_q == ST_VOUT) ? py_q : px_q;
    vsum  = 38'((rnd >>> 31) + 69'(vbase));
    vsat = (vsum > 38'sd2147483647) ? 32'sh7fffffff :
           (vsum < -38'sd2147483648) ? 32'sh80000000 : vsum[31:0];
  end

  always_comb begin
    state_d = state_q; next_d = next_q; count_d = count_q;
    flush_ret_d = flush_ret_q; idx_d = idx_q; slot_d = slot_q;
    rd_pend_d = 1'b0; corner_d = corner_q; acc_d = acc_q; vx_d = vx_q;
    ov_d = ov_q && !out_ready_i;
    okind_d = okind_q; ox_d = ox_q; oy_d = oy_q; ou_d = ou_q; ovv_d = ovv_q;
    oslot_d = oslot_q; otex_d = otex_q; ocnt_d = ocnt_q; olast_d = olast_q;
    ram_we = 1'b0; ram_wa = next_q[SLOT_W-1:0]; ram_ra = idx_q[SLOT_W-1:0];
    cctl.start = 1'b0; cctl.busy = (state_q == ST_CORDIC);
    mul_a = cosv; mul_b = hx;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          idx_d = NSLOT_W'(1);
          if (mode_i) begin
            flush_ret_d = 1'b0; state_d = ST_FBIND;
          end else if (count_q >= limit_q) begin
            flush_ret_d = 1'b1; state_d = ST_FBIND;
          end else begin
            state_d = ST_SEARCH; idx_d = NSLOT_W'(2);
          end
        end
      end
      ST_FBIND: begin
        if (idx_q < next_q && idx_q < NSLOT_W'(SLOT_COUNT)) begin
          if (idx_q != NSLOT_W'(1) && !rd_pend_q && !ov_q) begin
            rd_pend_d = 1'b1;
          end else if (out_free && (idx_q == NSLOT_W'(1) || rd_pend_q)) begin
            ov_d = 1'b1; okind_d = KIND_BIND; ox_d = '0; oy_d = '0;
            ou_d = 1'b0; ovv_d = 1'b0; ocnt_d = '0; olast_d = 1'b0;
            oslot_d = 4'(idx_q);
            otex_d = 16'(idx_q == NSLOT_W'(1) ? white_q : ram_rd);
            idx_d = idx_q + 1'b1;
          end else begin
            rd_pend_d = rd_pend_q;
          end
        end else begin
          state_d = ST_FDRAW;
        end
      end
      ST_FDRAW: begin
        if (out_free) begin
          ov_d = 1'b1; okind_d = KIND_DRAW; ox_d = '0; oy_d = '0;
          ou_d = 1'b0; ovv_d = 1'b0; oslot_d = '0; otex_d = '0;
          ocnt_d = 17'(count_q) * 17'd6; olast_d = !flush_ret_q;
          count_d = '0; next_d = NSLOT_W'(2);
          state_d = flush_ret_q ? ST_SEARCH : ST_IDLE;
          idx_d = NSLOT_W'(2); flush_ret_d = 1'b0;
        end
      end
      ST_SEARCH: begin
        if (tex_q == white_q) begin
          slot_d = SLOT_W'(1); state_d = ST_CORDIC; cctl.start = 1'b1;
        end else if (idx_q < next_q && idx_q < NSLOT_W'(SLOT_COUNT)) begin
          if (!rd_pend_q) begin
            rd_pend_d = 1'b1;
          end else if (ram_rd == tex_q) begin
            slot_d = idx_q[SLOT_W-1:0]; state_d = ST_CORDIC; cctl.start = 1'b1;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end else if (next_q >= NSLOT_W'(SLOT_COUNT)) begin
          flush_ret_d = 1'b1; idx_d = NSLOT_W'(1); state_d = ST_FBIND;
        end else begin
          state_d = ST_ALLOC;
        end
      end
      ST_ALLOC: begin
        ram_we = 1'b1; slot_d = next_q[SLOT_W-1:0]; next_d = next_q + 1'b1;
        state_d = ST_CORDIC; cctl.start = 1'b1;
      end
      ST_CORDIC: begin
        corner_d = '0;
        if (cdone) state_d = ST_MUL0;
      end
      ST_MUL0: begin mul_a = cosv; mul_b = hx; state_d = ST_MUL1; end
      ST_MUL1: begin
        mul_a = sinv; mul_b = -hy; acc_d = prod_q; state_d = ST_MUL2;
      end
      ST_MUL2: begin
        mul_a = sinv; mul_b = hx; acc_d = acc_q + prod_q;
        state_d = ST_MUL3;
      end
      ST_MUL3: begin
        mul_a = cosv; mul_b = hy; vx_d = vsat; acc_d = prod_q;
        state_d = ST_ADD;
      end
      ST_ADD: begin
        acc_d = acc_q + prod_q; state_d = ST_VOUT;
      end
      ST_VOUT: begin
        if (out_free) begin
          ov_d = 1'b1; okind_d = KIND_VERTEX; ox_d = vx_q; oy_d = vsat;
          ou_d = (corner_q == 2'd1 || corner_q == 2'd2);
          ovv_d = corner_q[1]; oslot_d = 4'(slot_q); otex_d = '0;
          ocnt_d = '0; olast_d = (corner_q == 2'd3);
          corner_d = corner_q + 1'b1;
          if (corner_q == 2'd3) begin
            state_d = ST_IDLE; count_d = count_q + 1'b1;
          end else begin
            state_d = ST_MUL0;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; limit_q <= 14'd10000; white_q <= '0;
      next_q <= NSLOT_W'(2); count_q <= '0; ov_q <= 1'b0;
      rd_pend_q <= 1'b0; flush_ret_q <= 1'b0;
    end else begin
      state_q <= state_d; next_q <= next_d; count_q <= count_d;
      ov_q <= ov_d; rd_pend_q <= rd_pend_d; flush_ret_q <= flush_ret_d;
      if (cfg_we_i && cfg_index_i == REG_QUAD_LIMIT) limit_q <= cfg_data_i[13:0];
      if (cfg_we_i && cfg_index_i == REG_WHITE_TEX) white_q <= cfg_data_i[TEX_ID_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      px_q <= pos_x_i; py_q <= pos_y_i; pz_q <= pos_z_i;
      sx_q <= size_x_i; sy_q <= size_y_i; ang_q <= angle_i;
      col_q <= color_rgba_i; tex_q <= texture_id_i[TEX_ID_BITS-1:0];
    end
    idx_q <= idx_d; slot_q <= slot_d; corner_q <= corner_d; acc_q <= acc_d;
    vx_q <= vx_d; prod_q <= 69'(mul_a) * 69'(mul_b);
    okind_q <= okind_d; ox_q <= ox_d; oy_q <= oy_d; ou_q <= ou_d;
    ovv_q <= ovv_d; oslot_q <= oslot_d; otex_q <= otex_d; ocnt_q <= ocnt_d;
    olast_q <= olast_d;
  end

  assign out_valid_o     = ov_q;
  assign kind_o          = okind_q;
  assign vertex_x_o      = ox_q;
  assign vertex_y_o      = oy_q;
  assign vertex_z_o      = (okind_q == KIND_VERTEX) ? pz_q : '0;
  assign vertex_color_o  = (okind_q == KIND_VERTEX) ? col_q : '0;
  assign tex_u_o         = ou_q;
  assign tex_v_o         = ovv_q;
  assign slot_o          = oslot_q;
  assign bound_texture_o = otex_q;
  assign index_count_o   = ocnt_q;
  assign last_o          = olast_q;
endmodule

FILE: src/qbvs_checker.sv
// ----------------------------------------------------------------------------
// qbvs_checker
// Port-level checks of the quad batch vertex setup block.
// ----------------------------------------------------------------------------
module qbvs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  kind_o,
  input logic [16:0] index_count_o,
  input logic        last_o
);
  import qbvs_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kind_o))
    else $error("result dropped while stalled");

  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("request taken with result pending");

  a_draw_mult6: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_DRAW |-> index_count_o % 6 == 0)
    else $error("index count not a multiple of six");

  a_bind_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_BIND |-> !last_o)
    else $error("bind marked last");
endmodule

bind quad_batch_vertex_setup qbvs_checker u_qbvs_checker (.*);

FILE: dv/quad_batch_vertex_setup_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quad_batch_vertex_setup_tb
// Self-checking bench for the quad batcher. Draw and flush requests are
// driven in bursts over several register settings. A batch model predicts
// vertex, bind and draw results, which are compared in order on the output.
// ----------------------------------------------------------------------------
module quad_batch_vertex_setup_tb;
  import qbvs_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD      = 400;

  typedef struct {
    logic               mode;
    logic signed [31:0] px, py, pz, sx, sy;
    logic signed [14:0] angle;
    logic [31:0]        color;
    logic [15:0]        tex;
  } quad_req_t;

  typedef struct {
    logic [1:0]  kind;
    logic [31:0] vx, vy, vz, color;
    logic        u, v;
    logic [3:0]  slot;
    logic [15:0] btex;
    logic [16:0] icnt;
    logic        last;
  } batch_res_t;

  class batch_scoreboard;
    batch_res_t  pending_q[$];
    int          errors = 0;
    logic [13:0] quad_limit = 14'd10000;
    logic [15:0] white_tex = '0;
    logic [15:0] slot_tex[SLOT_COUNT];
    int          next_slot = 2;
    logic [13:0] quad_count = '0;
    longint      atan_tab[16] = '{843314857, 497837829, 263043837, 133525159, 67021687,
      33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
      65536, 32768};

    function void write_reg(logic idx, logic [15:0] data);
      if (idx == REG_QUAD_LIMIT) quad_limit = data[13:0];
      else white_tex = data;
    endfunction

    function void emit(logic [1:0] kind, logic [31:0] vx, logic [31:0] vy, logic [31:0] vz,
                       logic [31:0] color, logic u, logic v, logic [3:0] slot,
                       logic [15:0] btex, logic [16:0] icnt);
      batch_res_t r;
      r = '{kind, vx, vy, vz, color, u, v, slot, btex, icnt, 1'b0};
      pending_q.push_back(r);
    endfunction

    function void flush_batch();
      for (int i = 1; i < next_slot && i < SLOT_COUNT; i++)
        emit(KIND_BIND, 0, 0, 0, 0, 0, 0, i[3:0], (i == 1) ? white_tex : slot_tex[i], 0);
      emit(KIND_DRAW, 0, 0, 0, 0, 0, 0, 0, 0, 17'(quad_count * 6));
      quad_count = '0;
      next_slot = 2;
    endfunction

    function longint sat(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function void note_request(quad_req_t rq);
      longint a, x, y, t, c, s, hx, hy, rx, ry, vx, vy;
      int     slot, cx[4], cy[4];
      bit     neg, found;
      cx = '{-1, 1, 1, -1};
      cy = '{1, 1, -1, -1};
      if (rq.mode) begin
        flush_batch();
        pending_q[pending_q.size()-1].last = 1'b1;
        return;
      end
      if (quad_count >= quad_limit) flush_batch();
      slot = 1;
      if (rq.tex != white_tex) begin
        found = 0;
        for (int i = 2; i < next_slot && i < SLOT_COUNT; i++)
          if (!found && slot_tex[i] == rq.tex) begin
            slot = i;
            found = 1;
          end
        if (!found) begin
          if (next_slot >= SLOT_COUNT) flush_batch();
          slot_tex[next_slot] = rq.tex;
          slot = next_slot;
          next_slot++;
        end
      end
      a = longint'(rq.angle) * 262144;
      x = 652032874;
      y = 0;
      neg = 0;
      if (a > 64'sd1686629713) begin
        a -= 64'sd3373259426; neg = 1;
      end else if (a < -64'sd1686629713) begin
        a += 64'sd3373259426; neg = 1;
      end
      for (int i = 0; i < 16; i++) begin
        if (a >= 0) begin
          t = x - (y >>> i); y = y + (x >>> i); a -= atan_tab[i];
        end else begin
          t = x + (y >>> i); y = y - (x >>> i); a += atan_tab[i];
        end
        x = t;
      end
      c = neg ? -x : x;
      s = neg ? -y : y;
      for (int k = 0; k < 4; k++) begin
        hx = cx[k] * longint'(rq.sx);
        hy = cy[k] * longint'(rq.sy);
        rx = hx * c - hy * s;
        ry = hx * s + hy * c;
        vx = sat(longint'(rq.px) + ((rx + (64'sd1 <<< 30)) >>> 31));
        vy = sat(longint'(rq.py) + ((ry + (64'sd1 <<< 30)) >>> 31));
        emit(KIND_VERTEX, vx[31:0], vy[31:0], rq.pz, rq.color, (k == 1 || k == 2),
             (k >= 2), slot[3:0], 0, 0);
      end
      quad_count = quad_count + 1'b1;
      pending_q[pending_q.size()-1].last = 1'b1;
    endfunction

    function void cmp(string name, logic [31:0] exp, logic [31:0] act);
      if (exp !== act) begin
        $error("%s: expected %0h, got %0h", name, exp, act);
        errors++;
      end
    endfunction

    function void check_result(batch_res_t r);
      batch_res_t e;
      if (pending_q.size() == 0) begin
        $error("result with nothing outstanding, kind %0d", r.kind);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      cmp("kind", e.kind, r.kind);
      cmp("vertex_x", e.vx, r.vx);
      cmp("vertex_y", e.vy, r.vy);
      cmp("vertex_z", e.vz, r.vz);
      cmp("vertex_color", e.color, r.color);
      cmp("tex_u", e.u, r.u);
      cmp("tex_v", e.v, r.v);
      cmp("slot", e.slot, r.slot);
      cmp("bound_texture", e.btex, r.btex);
      cmp("index_count", e.icnt, r.icnt);
      cmp("last", e.last, r.last);
    endfunction
  endclass

  logic clk_i = 0, rst_ni = 0;
  logic cfg_we_i = 0, cfg_index_i = 0;
  logic [15:0] cfg_data_i = '0;
  logic in_valid_i = 0, in_ready_o, mode_i = 0;
  logic signed [31:0] pos_x_i = '0, pos_y_i = '0, pos_z_i = '0, size_x_i = '0, size_y_i = '0;
  logic signed [14:0] angle_i = '0;
  logic [31:0] color_rgba_i = '0;
  logic [15:0] texture_id_i = '0;
  logic out_valid_o, out_ready_i = 0;
  logic [1:0] kind_o;
  logic signed [31:0] vertex_x_o, vertex_y_o, vertex_z_o;
  logic [31:0] vertex_color_o;
  logic tex_u_o, tex_v_o, last_o;
  logic [3:0] slot_o;
  logic [15:0] bound_texture_o;
  logic [16:0] index_count_o;

  quad_batch_vertex_setup uut (.*);

  always #1 clk_i = ~clk_i;

  batch_scoreboard sb = new;
  int  idle_cycles = 0;
  bit  hold_req = 0;
  int  burst_left = 0;
  logic [15:0] tex_pool[8];

  always @(posedge clk_i) begin
    batch_res_t r;
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
    if (out_valid_o && out_ready_i) begin
      r = '{kind_o, vertex_x_o, vertex_y_o, vertex_z_o, vertex_color_o, tex_u_o, tex_v_o,
            slot_o, bound_texture_o, index_count_o, last_o};
      sb.check_result(r);
    end
  end

  // receiver stall pattern, with a long hold-off on request
  initial begin
    int pat;
    forever begin
      pat = $urandom_range(0, 3);
      for (int i = 0; i < 64; i++) begin
        @(posedge clk_i);
        if (hold_req) begin
          out_ready_i <= 1'b0;
          repeat (LONG_HOLD) @(posedge clk_i);
          hold_req = 0;
        end
        case (pat)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= $urandom_range(0, 1);
          2: out_ready_i <= (i % 4 == 0);
          default: out_ready_i <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  task automatic send_request(quad_req_t rq);
    in_valid_i <= 1'b1;
    mode_i <= rq.mode;
    pos_x_i <= rq.px; pos_y_i <= rq.py; pos_z_i <= rq.pz;
    size_x_i <= rq.sx; size_y_i <= rq.sy;
    angle_i <= rq.angle; color_rgba_i <= rq.color; texture_id_i <= rq.tex;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(rq);
    if (burst_left > 0) burst_left--;
    else begin
      burst_left = $urandom_range(0, 20);
      if ($urandom_range(0, 3) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic set_config(logic [13:0] limit, logic [15:0] white);
    wait_drained();
    cfg_we_i <= 1'b1; cfg_index_i <= REG_QUAD_LIMIT; cfg_data_i <= {2'b0, limit};
    @(posedge clk_i);
    sb.write_reg(REG_QUAD_LIMIT, {2'b0, limit});
    cfg_index_i <= REG_WHITE_TEX; cfg_data_i <= white;
    @(posedge clk_i);
    sb.write_reg(REG_WHITE_TEX, white);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] rnd_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(0, 2097152)) - 1048576);
    endcase
  endfunction

  function automatic quad_req_t rnd_request();
    quad_req_t rq;
    rq.mode = ($urandom_range(0, 11) == 0);
    rq.px = rnd_coord(); rq.py = rnd_coord(); rq.pz = $urandom;
    rq.sx = rnd_coord(); rq.sy = rnd_coord();
    rq.angle = ($urandom_range(0, 1)) ? 15'($urandom) :
               15'($signed($urandom_range(0, 25736)) - 12868);
    rq.color = $urandom;
    case ($urandom_range(0, 4))
      0: rq.tex = sb.white_tex;
      1: rq.tex = 16'($urandom);
      default: rq.tex = tex_pool[$urandom_range(0, 7)];
    endcase
    return rq;
  endfunction

  task automatic random_phase(int n, bit hold);
    for (int i = 0; i < n; i++) begin
      if (hold && i == 5) hold_req = 1;
      if (i == n / 2) wait_drained();
      send_request(rnd_request());
    end
  endtask

  task automatic directed_quad(logic [14:0] ang, logic [31:0] p, logic [31:0] sz,
                               logic [15:0] tex);
    quad_req_t rq;
    rq = '{1'b0, p, ~p, $urandom, sz, sz, ang, $urandom, tex};
    send_request(rq);
  endtask

  initial begin
    quad_req_t fl;
    fl = '{1'b1, 0, 0, 0, 0, 0, 0, 0, 0};
    foreach (tex_pool[i]) tex_pool[i] = 16'($urandom);
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty flush, extremes of angle and coordinates, slot exhaustion
    send_request(fl);
    directed_quad(15'sd0, 32'h0001_0000, 32'h0002_0000, 16'h0000);
    directed_quad(15'sd12868, 32'h7fffffff, 32'h7fffffff, 16'hffff);
    directed_quad(-15'sd12868, 32'h80000000, 32'h80000000, 16'hffff);
    directed_quad(15'sd6434, 32'h0, 32'h7fffffff, 16'h0001);
    directed_quad(-15'sd6434, 32'h0, 32'h80000000, 16'h0000);
    directed_quad(15'h3fff, 32'h7fffffff, 32'h80000000, 16'h0002);
    directed_quad(15'h4000, 32'h80000000, 32'h7fffffff, 16'h0003);
    for (int i = 0; i < 14; i++) directed_quad(15'($urandom), $urandom, $urandom, 16'(100 + i));
    send_request(fl);

    random_phase(90, 1);
    set_config(14'd1, 16'hffff);
    random_phase(90, 0);
    set_config(14'd3, 16'h1234);
    random_phase(90, 1);
    set_config(14'd16383, tex_pool[0]);
    random_phase(100, 0);
    set_config(14'd0, 16'h0000);
    random_phase(90, 0);

    in_valid_i <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (sb.errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
